// ===== rtl/core/psa_pkg.sv =====
// Package for the page segment worst-fit allocator.
// Holds table sizes, status and register codes, and the sequencer state type.
// No dependencies.
package psa_pkg;

  localparam int TableDepth = 1024;
  localparam int PageBytes  = 4096;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int PageShift  = $clog2(PageBytes);

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_ZERO    = 3'd2,
    ST_ROUTE   = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_PAGE_START  = 3'd0,
    REG_HEAP_LIMIT  = 3'd1,
    REG_SMALL_LIMIT = 3'd2,
    REG_BLOCK_START = 3'd3,
    REG_BLOCK_END   = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADEC,        // allocate: checks
    S_ASCAN_RD,    // scan: issue read
    S_ASCAN,       // scan: evaluate entry
    S_AEXACT,      // exact fit: entry i-1 was written in scan
    S_AWORST,      // worst fit: start the shift
    S_SHR_RD,      // shift up: read entry k-1
    S_SHR_WR,      // shift up: write entry k
    S_SPLIT0,      // write granted entry
    S_SPLIT1,      // write remainder entry
    S_APPEND,      // append at break
    S_FDEC,        // free: checks
    S_FFIND_RD,
    S_FFIND,
    S_FBRK_RD,     // break pull-down scan
    S_FBRK,
    S_FTRIM_RD,    // drop trailing free entries
    S_FTRIM,
    S_MRG_RD0,     // merge: read entry i
    S_MRG_RD1,     // merge: read entry i+1
    S_MRG_CHK,
    S_SHL_RD,      // shift down: read entry k+1
    S_SHL_WR,      // shift down: write entry k
    S_OUT
  } state_t;

endpackage

// ===== rtl/core/page_segment_worst_fit_allocator_core.sv =====
// Page segment worst-fit allocator, top level.
// One sequencer walks a segment table with one read and one write port; uses psa_pkg.
//
// Channel  | Dir | Handshake                 | Payload
// s_axis   | in  | s_axis_tvalid/tready      | tdata: request_size, region_address; tuser: operation
// m_axis   | out | m_axis_tvalid/tready      | tdata: status, granted_address
// cfg      | in  | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// An allocate scans the entries and, for a split, moves the entries above the gap up.
// A free searches the entries, may pull the break down and drop trailing free entries,
// then merge-checks neighbouring entries and moves entries down over a merged one.
// rst (synchronous) clears the count and the break and loads the config defaults; the table is undefined.
// s_axis_tready is high only in idle; a held result stalls the next request.
module page_segment_worst_fit_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] request_size, [63:32] region_address
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [2:0] status, [34:3] granted_address, [39:35] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = psa_pkg::IdxW;
  localparam int CW = psa_pkg::CntW;
  localparam int PS = psa_pkg::PageShift;

  // segment table memory
  logic [31:0] mem_start [psa_pkg::TableDepth];
  logic [31:0] mem_len   [psa_pkg::TableDepth];
  logic [IW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [31:0]   wr_start, wr_len, rd_start, rd_len;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr]   <= wr_len;
    end
    rd_start <= mem_start[rd_addr];
    rd_len   <= mem_len[rd_addr];
  end

  // config registers
  logic [31:0] page_area_start, heap_limit, block_area_start, block_area_end;
  logic [15:0] small_block_limit;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      page_area_start   <= '0;
      heap_limit        <= '1;
      small_block_limit <= 16'd2048;
      block_area_start  <= '0;
      block_area_end    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        psa_pkg::REG_PAGE_START:  page_area_start   <= cfg_data;
        psa_pkg::REG_HEAP_LIMIT:  heap_limit        <= cfg_data;
        psa_pkg::REG_SMALL_LIMIT: small_block_limit <= cfg_data[15:0];
        psa_pkg::REG_BLOCK_START: block_area_start  <= cfg_data;
        psa_pkg::REG_BLOCK_END:   block_area_end    <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and working registers
  psa_pkg::state_t state, state_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [31:0]   heap_break, heap_break_next;
  logic [31:0]   size, size_next;        // request size, or address for free
  logic [32:0]   r64, r64_next;          // rounded size
  logic [CW-1:0] i, i_next;              // scan index
  logic [CW-1:0] k, k_next;              // shift index
  logic          have_first, have_first_next;
  logic [32:0]   gap, gap_next;
  logic [32:0]   worst, worst_next;
  logic [31:0]   widest_va, widest_va_next;
  logic [CW-1:0] ins, ins_next;
  logic [31:0]   first_va, first_va_next, first_len, first_len_next;
  logic [31:0]   hold_s, hold_s_next, hold_l, hold_l_next;   // entry held between reads
  logic [32:0]   nb, nb_next;
  logic [2:0]    status, status_next;
  logic [31:0]   gaddr, gaddr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= psa_pkg::S_IDLE;
      entry_count <= '0;
      heap_break  <= '0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      heap_break  <= heap_break_next;
    end
    size <= size_next;  r64 <= r64_next;
    i <= i_next;  k <= k_next;  have_first <= have_first_next;
    gap <= gap_next;  worst <= worst_next;  widest_va <= widest_va_next;
    ins <= ins_next;  first_va <= first_va_next;  first_len <= first_len_next;
    hold_s <= hold_s_next;  hold_l <= hold_l_next;  nb <= nb_next;
    status <= status_next;  gaddr <= gaddr_next;
  end

  // shared adder: end of a segment, or break plus size
  logic [31:0] add_a, add_b;
  logic [32:0] add_y;
  assign add_y = {1'b0, add_a} + {1'b0, add_b};

  logic [32:0] rnd;
  assign rnd = {1'b0, size} + 33'(psa_pkg::PageBytes - 1);

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      psa_pkg::S_IDLE:
        if (s_axis_tvalid) state_next = s_axis_tuser ? psa_pkg::S_FDEC : psa_pkg::S_ADEC;
      psa_pkg::S_ADEC:
        if (size == '0 || size <= {16'd0, small_block_limit} || rnd[32])
          state_next = psa_pkg::S_OUT;
        else if (entry_count == '0) state_next = psa_pkg::S_APPEND;
        else state_next = psa_pkg::S_ASCAN_RD;
      psa_pkg::S_ASCAN_RD: state_next = psa_pkg::S_ASCAN;
      psa_pkg::S_ASCAN:
        if (rd_start != '0 && have_first && gap == r64) state_next = psa_pkg::S_AEXACT;
        else if (i + 1'b1 < entry_count) state_next = psa_pkg::S_ASCAN_RD;
        else state_next = psa_pkg::S_AWORST;
      psa_pkg::S_AEXACT: state_next = psa_pkg::S_OUT;
      psa_pkg::S_AWORST:
        if (worst == '0) state_next = psa_pkg::S_APPEND;
        else if (entry_count >= CW'(psa_pkg::TableDepth)) state_next = psa_pkg::S_OUT;
        else if (k > ins) state_next = psa_pkg::S_SHR_RD;
        else state_next = psa_pkg::S_SPLIT0;
      psa_pkg::S_SHR_RD: state_next = psa_pkg::S_SHR_WR;
      psa_pkg::S_SHR_WR:
        state_next = (k - 1'b1 > ins) ? psa_pkg::S_SHR_RD : psa_pkg::S_SPLIT0;
      psa_pkg::S_SPLIT0: state_next = psa_pkg::S_SPLIT1;
      psa_pkg::S_SPLIT1: state_next = psa_pkg::S_OUT;
      psa_pkg::S_APPEND: state_next = psa_pkg::S_OUT;
      psa_pkg::S_FDEC:
        if (size >= block_area_start && size < block_area_end) state_next = psa_pkg::S_OUT;
        else if (!(size >= page_area_start && size < heap_break)) state_next = psa_pkg::S_OUT;
        else if (entry_count == '0) state_next = psa_pkg::S_MRG_RD0;
        else state_next = psa_pkg::S_FFIND_RD;
      psa_pkg::S_FFIND_RD: state_next = psa_pkg::S_FFIND;
      psa_pkg::S_FFIND:
        if (rd_start != '0 && rd_start == size)
          state_next = (add_y == {1'b0, heap_break}) ? psa_pkg::S_FBRK_RD
                                                     : psa_pkg::S_MRG_RD0;
        else if (i + 1'b1 < entry_count) state_next = psa_pkg::S_FFIND_RD;
        else state_next = psa_pkg::S_MRG_RD0;
      psa_pkg::S_FBRK_RD: state_next = psa_pkg::S_FBRK;
      psa_pkg::S_FBRK:
        state_next = (i + 1'b1 < entry_count) ? psa_pkg::S_FBRK_RD : psa_pkg::S_FTRIM_RD;
      psa_pkg::S_FTRIM_RD:
        state_next = (entry_count == '0) ? psa_pkg::S_MRG_RD0 : psa_pkg::S_FTRIM;
      psa_pkg::S_FTRIM:
        state_next = (rd_start == '0) ? psa_pkg::S_FTRIM_RD : psa_pkg::S_MRG_RD0;
      psa_pkg::S_MRG_RD0:
        state_next = (i + 1'b1 < entry_count) ? psa_pkg::S_MRG_RD1 : psa_pkg::S_OUT;
      psa_pkg::S_MRG_RD1: state_next = psa_pkg::S_MRG_CHK;
      psa_pkg::S_MRG_CHK:
        if (hold_s == '0 && rd_start == '0)
          state_next = (k + 1'b1 < entry_count) ? psa_pkg::S_SHL_RD : psa_pkg::S_MRG_RD0;
        else state_next = psa_pkg::S_MRG_RD0;
      psa_pkg::S_SHL_RD: state_next = psa_pkg::S_SHL_WR;
      psa_pkg::S_SHL_WR:
        state_next = (k + 2'd2 < entry_count) ? psa_pkg::S_SHL_RD : psa_pkg::S_MRG_RD0;
      psa_pkg::S_OUT:
        if (m_axis_tready) state_next = psa_pkg::S_IDLE;
      default: state_next = psa_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    entry_count_next = entry_count;  heap_break_next = heap_break;
    size_next = size;  r64_next = r64;  i_next = i;  k_next = k;
    have_first_next = have_first;  gap_next = gap;  worst_next = worst;
    widest_va_next = widest_va;  ins_next = ins;  first_va_next = first_va;
    first_len_next = first_len;  hold_s_next = hold_s;  hold_l_next = hold_l;
    nb_next = nb;  status_next = status;  gaddr_next = gaddr;
    rd_addr = i[IW-1:0];  wr_addr = i[IW-1:0];  wr_en = 1'b0;
    wr_start = '0;  wr_len = '0;
    add_a = rd_start;  add_b = rd_len;
    unique case (state)
      psa_pkg::S_IDLE: begin
        size_next = s_axis_tuser ? s_axis_tdata[63:32] : s_axis_tdata[31:0];
        i_next = '0;  have_first_next = 1'b0;  gap_next = '0;  worst_next = '0;
        status_next = psa_pkg::ST_DONE;  gaddr_next = '0;
      end
      psa_pkg::S_ADEC: begin
        r64_next = {rnd[32:PS], {PS{1'b0}}};
        if (size == '0) status_next = psa_pkg::ST_ZERO;
        else if (size <= {16'd0, small_block_limit}) status_next = psa_pkg::ST_ROUTE;
        else if (rnd[32]) status_next = psa_pkg::ST_NOSPACE;
        else if (entry_count == '0) heap_break_next = page_area_start;
      end
      psa_pkg::S_ASCAN: begin
        if (rd_start == '0) begin
          if (have_first) gap_next = gap + {1'b0, rd_len};
        end else begin
          if (have_first) begin
            add_a = first_va;  add_b = first_len;
            if (gap == r64) begin
              wr_en = 1'b1;  wr_addr = IW'(i - 1'b1);
              wr_start = add_y[31:0];  wr_len = r64[31:0];
              gaddr_next = add_y[31:0];
            end else if (gap > r64 && gap > worst) begin
              worst_next = gap;  widest_va_next = add_y[31:0];  ins_next = k + 1'b1;
            end
            gap_next = '0;
          end
          have_first_next = 1'b1;
          first_va_next = rd_start;  first_len_next = rd_len;  k_next = i;
        end
        i_next = i + 1'b1;
      end
      psa_pkg::S_AWORST: begin
        if (worst != '0 && entry_count >= CW'(psa_pkg::TableDepth))
          status_next = psa_pkg::ST_NOSPACE;
        k_next = entry_count;
      end
      psa_pkg::S_SHR_RD: rd_addr = IW'(k - 1'b1);
      psa_pkg::S_SHR_WR: begin
        wr_en = 1'b1;  wr_addr = k[IW-1:0];  wr_start = rd_start;  wr_len = rd_len;
        k_next = k - 1'b1;
      end
      psa_pkg::S_SPLIT0: begin
        wr_en = 1'b1;  wr_addr = ins[IW-1:0];  wr_start = widest_va;  wr_len = r64[31:0];
        gaddr_next = widest_va;  entry_count_next = entry_count + 1'b1;
      end
      psa_pkg::S_SPLIT1: begin
        wr_en = 1'b1;  wr_addr = IW'(ins + 1'b1);  wr_start = '0;
        wr_len = 32'(worst - r64);
      end
      psa_pkg::S_APPEND: begin
        add_a = heap_break;  add_b = r64[31:0];
        if (entry_count >= CW'(psa_pkg::TableDepth) || add_y > {1'b0, heap_limit})
          status_next = psa_pkg::ST_NOSPACE;
        else begin
          wr_en = 1'b1;  wr_addr = entry_count[IW-1:0];
          wr_start = heap_break;  wr_len = r64[31:0];
          gaddr_next = heap_break;  heap_break_next = add_y[31:0];
          entry_count_next = entry_count + 1'b1;
        end
      end
      psa_pkg::S_FDEC: begin
        if (size >= block_area_start && size < block_area_end)
          status_next = psa_pkg::ST_ROUTE;
        else status_next = psa_pkg::ST_INVALID;
        nb_next = {1'b0, page_area_start};
      end
      psa_pkg::S_FFIND: begin
        if (rd_start != '0 && rd_start == size) begin
          wr_en = 1'b1;  wr_start = '0;  wr_len = rd_len;
          status_next = psa_pkg::ST_DONE;
          i_next = '0;
        end else i_next = (i + 1'b1 < entry_count) ? i + 1'b1 : '0;
      end
      psa_pkg::S_FBRK: begin
        if (rd_start != '0 && add_y <= {1'b0, size} && add_y > nb) nb_next = add_y;
        if (i + 1'b1 < entry_count) i_next = i + 1'b1;
        else heap_break_next = nb_next[31:0];
      end
      psa_pkg::S_FTRIM_RD: rd_addr = IW'(entry_count - 1'b1);
      psa_pkg::S_FTRIM: begin
        if (rd_start == '0) entry_count_next = entry_count - 1'b1;
        i_next = '0;
      end
      psa_pkg::S_MRG_RD1: begin
        hold_s_next = rd_start;  hold_l_next = rd_len;
        rd_addr = IW'(i + 1'b1);  k_next = i + 1'b1;
      end
      psa_pkg::S_MRG_CHK: begin
        if (hold_s == '0 && rd_start == '0) begin
          wr_en = 1'b1;  wr_start = '0;  wr_len = hold_l + rd_len;
          if (!(k + 1'b1 < entry_count)) entry_count_next = entry_count - 1'b1;
        end else i_next = i + 1'b1;
      end
      psa_pkg::S_SHL_RD: rd_addr = IW'(k + 1'b1);
      psa_pkg::S_SHL_WR: begin
        wr_en = 1'b1;  wr_addr = k[IW-1:0];  wr_start = rd_start;  wr_len = rd_len;
        k_next = k + 1'b1;
        if (!(k + 2'd2 < entry_count)) entry_count_next = entry_count - 1'b1;
      end
      default: ;
    endcase
    // merge step 0 reads entry i; hold it for the compare
    if (state == psa_pkg::S_MRG_RD0) rd_addr = i[IW-1:0];
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state)
      psa_pkg::S_IDLE: s_axis_tready = 1'b1;
      psa_pkg::S_OUT:  m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end
  assign m_axis_tdata = {5'd0, gaddr, status};

endmodule

// ===== test/page_segment_worst_fit_allocator_core_tb.sv =====
// Testbench for page_segment_worst_fit_allocator_core: drives allocate and free requests
// through several register settings and checks each response against a predictor.
// Depends on psa_pkg and the core RTL.
`timescale 1ns / 1ps

module page_segment_worst_fit_allocator_core_tb;

  // Predicts the segment table, break and responses; keeps the pending responses.
  class seg_alloc_scoreboard;
    bit [31:0] seg_va[$];
    bit [31:0] seg_bytes[$];
    bit [31:0] brk;
    bit [31:0] area_start, limit, blk_start, blk_end;
    bit [15:0] small_max;
    psa_pkg::status_t want_status[$];
    bit [31:0] want_addr[$];
    int        errors;

    function new();
      seg_va.delete();
      seg_bytes.delete();
      area_start = 0;
      limit = 32'hFFFF_FFFF;
      small_max = 16'd2048;
      blk_start = 0;
      blk_end = 0;
      brk = 0;
      errors = 0;
    endfunction

    function void write_reg(psa_pkg::reg_idx_t idx, bit [31:0] d);
      case (idx)
        psa_pkg::REG_PAGE_START:  area_start = d;
        psa_pkg::REG_HEAP_LIMIT:  limit = d;
        psa_pkg::REG_SMALL_LIMIT: small_max = d[15:0];
        psa_pkg::REG_BLOCK_START: blk_start = d;
        psa_pkg::REG_BLOCK_END:   blk_end = d;
        default: ;
      endcase
    endfunction

    // grow the heap at the break
    function void append(bit [31:0] rounded, output psa_pkg::status_t st,
                         output bit [31:0] va);
      st = psa_pkg::ST_NOSPACE;
      va = 0;
      if (seg_va.size() >= psa_pkg::TableDepth) return;
      if ({32'b0, brk} + rounded > {32'b0, limit}) return;
      va = brk;
      seg_va.push_back(brk);
      seg_bytes.push_back(rounded);
      brk = brk + rounded;
      st = psa_pkg::ST_DONE;
    endfunction

    function void allocate(bit [31:0] size, output psa_pkg::status_t st,
                           output bit [31:0] va);
      bit [63:0] r64, gap, worst;
      bit [31:0] rounded, widest_va, first_va, first_len, a;
      int        first_idx, ins;
      bit        have_first;
      gap = 0; worst = 0; widest_va = 0; first_va = 0; first_len = 0;
      first_idx = 0; ins = 0; have_first = 0;
      st = psa_pkg::ST_DONE;
      va = 0;
      if (size == 0) begin
        st = psa_pkg::ST_ZERO;
        return;
      end
      if (size <= small_max) begin
        st = psa_pkg::ST_ROUTE;
        return;
      end
      r64 = (({32'b0, size} + psa_pkg::PageBytes - 1) / psa_pkg::PageBytes)
            * psa_pkg::PageBytes;
      if (r64 > 64'hFFFF_FFFF) begin
        st = psa_pkg::ST_NOSPACE;
        return;
      end
      rounded = r64[31:0];
      if (seg_va.size() == 0) begin
        brk = area_start;
        append(rounded, st, va);
        return;
      end
      // scan gaps between used segments: exact fit first, else remember the widest
      for (int i = 0; i < seg_va.size(); i++) begin
        if (seg_va[i] == 0) begin
          if (have_first) gap += seg_bytes[i];
          continue;
        end
        if (!have_first) begin
          have_first = 1;
        end else begin
          a = first_va + first_len;
          if (gap == r64) begin
            seg_va[i-1] = a;
            seg_bytes[i-1] = rounded;
            va = a;
            return;
          end
          if (gap > r64 && gap > worst) begin
            worst = gap;
            widest_va = a;
            ins = first_idx + 1;
          end
          gap = 0;
        end
        first_va = seg_va[i];
        first_len = seg_bytes[i];
        first_idx = i;
      end
      if (worst != 0) begin
        if (seg_va.size() >= psa_pkg::TableDepth) begin
          st = psa_pkg::ST_NOSPACE;
          return;
        end
        seg_va.insert(ins, widest_va);
        seg_bytes.insert(ins, rounded);
        seg_va[ins+1] = 0;
        seg_bytes[ins+1] = 32'(worst - r64);
        va = widest_va;
        return;
      end
      append(rounded, st, va);
    endfunction

    function void free_region(bit [31:0] va, output psa_pkg::status_t st);
      bit [63:0] seg_end, nb, e;
      int        i;
      st = psa_pkg::ST_INVALID;
      if (va >= blk_start && va < blk_end) begin
        st = psa_pkg::ST_ROUTE;
        return;
      end
      if (!(va >= area_start && va < brk)) return;
      foreach (seg_va[k]) begin
        if (seg_va[k] != 0 && seg_va[k] == va) begin
          seg_end = {32'b0, va} + seg_bytes[k];
          seg_va[k] = 0;
          st = psa_pkg::ST_DONE;
          // freed the top segment: pull the break down and drop trailing free entries
          if (seg_end == {32'b0, brk}) begin
            nb = {32'b0, area_start};
            foreach (seg_va[j]) begin
              if (seg_va[j] != 0) begin
                e = {32'b0, seg_va[j]} + seg_bytes[j];
                if (e <= va && e > nb) nb = e;
              end
            end
            brk = nb[31:0];
            while (seg_va.size() > 0 && seg_va[seg_va.size()-1] == 0) begin
              void'(seg_va.pop_back());
              void'(seg_bytes.pop_back());
            end
          end
          break;
        end
      end
      // coalesce neighboring free entries
      i = 0;
      while (i + 1 < seg_va.size()) begin
        if (seg_va[i] == 0 && seg_va[i+1] == 0) begin
          seg_bytes[i] += seg_bytes[i+1];
          seg_va.delete(i+1);
          seg_bytes.delete(i+1);
        end else begin
          i++;
        end
      end
    endfunction

    function void record_request(bit op, bit [31:0] size, bit [31:0] va);
      psa_pkg::status_t st;
      bit [31:0] grant;
      grant = 0;
      if (op == 1'b0) allocate(size, st, grant);
      else free_region(va, st);
      want_status.push_back(st);
      want_addr.push_back(grant);
    endfunction

    function void check_response(bit [2:0] st, bit [31:0] grant);
      if (want_status.size() == 0) begin
        $error("response with none pending: status %0d address %h", st, grant);
        errors++;
        return;
      end
      if (st !== want_status[0]) begin
        $error("status: expected %0d actual %0d", want_status[0], st);
        errors++;
      end
      if (grant !== want_addr[0]) begin
        $error("granted_address: expected %h actual %h", want_addr[0], grant);
        errors++;
      end
      void'(want_status.pop_front());
      void'(want_addr.pop_front());
    endfunction

    function int pending();
      return want_status.size();
    endfunction

    // a live segment start, or a random address when none is live
    function bit [31:0] pick_used();
      bit [31:0] live[$];
      foreach (seg_va[k]) if (seg_va[k] != 0) live.push_back(seg_va[k]);
      if (live.size() == 0) return $urandom;
      return live[$urandom_range(live.size()-1)];
    endfunction
  endclass

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  seg_alloc_scoreboard sb = new();
  int send_idle = 0, recv_idle = 0;
  int quiet_cycles = 0;
  int rand_count = 0;

  page_segment_worst_fit_allocator_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver readiness
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle);

  // response check and watchdog
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_response(m_axis_tdata[2:0], m_axis_tdata[34:3]);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 50000) begin
      $display("page_segment_worst_fit_allocator_core_tb: errors");
      $finish;
    end
  end

  task automatic send_request(bit op, bit [31:0] size, bit [31:0] va);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {va, size};
    do @(posedge clk); while (!s_axis_tready);
    sb.record_request(op, size, va);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(psa_pkg::reg_idx_t idx, bit [31:0] d);
    drain();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random mix: mostly allocations and frees of live segments, some noise
  task automatic run_random(int n);
    int        k, m;
    bit        op;
    bit [31:0] size, va;
    repeat (n) begin
      if (rand_count < 97) begin
        send_idle = 27; recv_idle = 47;
      end else if (rand_count < 194) begin
        send_idle = 47; recv_idle = 27;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      k = $urandom_range(99);
      size = $urandom;
      va = $urandom;
      if (k < 55) begin
        op = 1'b0;
        m = $urandom_range(9);
        if (m <= 6)
          size = $urandom_range(1, 6) * psa_pkg::PageBytes
                 - $urandom_range(0, psa_pkg::PageBytes - 1);
        else if (m == 8) size = $urandom_range(0, sb.small_max + 1);
        else if (m == 9) size = 32'hFFFF_F000 + $urandom_range(0, 4095);
      end else if (k < 88) begin
        op = 1'b1;
        va = sb.pick_used();
      end else begin
        op = 1'b1;
        m = $urandom_range(2);
        if (m == 0) va = sb.blk_start + $urandom_range(0, 4096);
        else if (m == 1) va = sb.brk;
      end
      send_request(op, size, va);
      rand_count++;
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = psa_pkg::REG_PAGE_START;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, heap at address zero
    send_request(1'b0, 32'd0, 32'hFFFF_FFFF);          // zero size
    send_request(1'b0, 32'd1, 32'd0);                  // small request
    send_request(1'b0, 32'd2048, 32'd0);               // at small limit
    send_request(1'b0, 32'hFFFF_FFFF, 32'd0);          // rounding overflow
    send_request(1'b0, 32'd2049, 32'd0);               // empty table, grant at zero
    send_request(1'b0, 32'd8192, 32'd0);
    send_request(1'b0, 32'd12288, 32'd0);
    send_request(1'b0, 32'd4096, 32'd0);
    send_request(1'b1, 32'd0, 32'h0000_2000);          // inside a segment, not its start
    send_request(1'b0, 32'd8000, 32'd0);               // no free gap, append at the break
    send_request(1'b1, 32'd0, 32'h0000_4000);          // inside a segment, not its start
    send_request(1'b0, 32'd4096, 32'd0);               // no free gap, append at the break
    send_request(1'b1, 32'd0, 32'h0000_5000);          // not a segment start
    send_request(1'b1, 32'd0, 32'hFFFF_0000);          // beyond the break
    send_request(1'b1, 32'd0, 32'h0000_7000);          // segment below the top one: no pull-down
    send_request(1'b0, 32'hFFFF_F000, 32'd0);          // past the limit
    drain();

    write_reg(psa_pkg::REG_BLOCK_START, 32'h0000_1000);
    write_reg(psa_pkg::REG_BLOCK_END, 32'h0000_3000);
    send_request(1'b1, 32'd0, 32'h0000_1000);          // block area free
    send_request(1'b1, 32'd0, 32'h0000_2FFF);

    // tight heap above a block area, every nonzero size goes to pages
    write_reg(psa_pkg::REG_PAGE_START, 32'h0040_0000);
    write_reg(psa_pkg::REG_HEAP_LIMIT, 32'h0044_0000);
    write_reg(psa_pkg::REG_SMALL_LIMIT, 32'h0000);
    run_random(100);

    // heap at the top of the address space, largest small limit
    write_reg(psa_pkg::REG_PAGE_START, 32'hFFF0_0000);
    write_reg(psa_pkg::REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    write_reg(psa_pkg::REG_SMALL_LIMIT, 32'hFFFF);
    write_reg(psa_pkg::REG_BLOCK_START, 32'h8000_0000);
    write_reg(psa_pkg::REG_BLOCK_END, 32'h8010_0000);
    run_random(100);

    // heap limit of zero, then a roomy heap
    write_reg(psa_pkg::REG_PAGE_START, 32'h0000_1000);
    write_reg(psa_pkg::REG_HEAP_LIMIT, 32'h0000_0000);
    run_random(10);
    write_reg(psa_pkg::REG_HEAP_LIMIT, 32'h0100_0000);
    write_reg(psa_pkg::REG_SMALL_LIMIT, 32'h0100);
    run_random(80);

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("page_segment_worst_fit_allocator_core_tb: clean");
    else
      $display("page_segment_worst_fit_allocator_core_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/psa_pkg.sv
rtl/core/page_segment_worst_fit_allocator_core.sv
test/page_segment_worst_fit_allocator_core_tb.sv
